@@ rtl/mdbdi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdbdi_pkg
// Shared types and constants of the block dequantizer and inverse DCT.
// ----------------------------------------------------------------------------
package mdbdi_pkg;

  // Item classes passed from the intake queue to the engine
  localparam logic [1:0] OP_CODE   = 2'd0;
  localparam logic [1:0] OP_QWRITE = 2'd1;
  localparam logic [1:0] OP_MWRITE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Input kinds
  localparam logic [1:0] KIND_CODE   = 2'd0;
  localparam logic [1:0] KIND_QWRITE = 2'd1;
  localparam logic [1:0] KIND_MWRITE = 2'd2;

  localparam logic [15:0] PAD_WORD = 16'hFE00;
  localparam logic [2:0]  LAST_BLOCK = 3'd5;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        word;
    logic [6:0]         idx;
    logic signed [15:0] tval;
  } item_t;

  localparam logic [5:0] ZIGZAG [64] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63};

endpackage

@@ rtl/mdbdi_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdbdi_front
// Intake: classify each word and hold it in a two-entry queue.
// ----------------------------------------------------------------------------
module mdbdi_front import mdbdi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [15:0]        code_word,
  input  logic [6:0]         table_index,
  input  logic signed [15:0] table_value,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      item_in;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_item  = entry[rd_ptr];

  // Fold meaningless items (kind 3, matrix index past 63) into no-ops
  always_comb begin
    item_in.word = code_word;
    item_in.idx  = table_index;
    item_in.tval = table_value;
    case (kind)
      KIND_CODE:   item_in.op = OP_CODE;
      KIND_QWRITE: item_in.op = OP_QWRITE;
      KIND_MWRITE: item_in.op = table_index[6] ? OP_NONE : OP_MWRITE;
      default:     item_in.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ rtl/mdbdi_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdbdi_back
// Engine: dequantize code words into the coefficient store, then run the
// two-pass inverse DCT on a shared multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module mdbdi_back import mdbdi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               strobe,
  output logic signed [15:0] sample,
  output logic [5:0]         sample_index,
  output logic [2:0]         block_number,
  output logic               last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_QRD  = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_IDCT = 3'd4;

  logic [2:0] state;
  logic       in_block;
  logic [5:0] scale;
  logic [6:0] pos;
  logic [2:0] bim;
  logic signed [9:0] lvl;
  logic       dc;
  logic [6:0] qaddr;

  // Stores
  logic [7:0]         qmem [128];
  logic [127:0]       qv;
  logic signed [15:0] mmem [64];
  logic signed [10:0] cmem [64];
  logic [63:0]        cv;
  logic signed [13:0] bufm [64];

  logic [7:0]         qdata;
  logic               qdv;
  logic signed [18:0] prod1;

  // Word intake
  logic [6:0] pos_sum;
  logic       pop_code, pop_open, pop_end, pop_coef;
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign pos_sum  = pos + {1'b0, q_item.word[15:10]} + 7'd1;
  assign pop_code = q_pop && (q_item.op == OP_CODE);
  assign pop_open = pop_code && !in_block && (q_item.word != PAD_WORD);
  assign pop_end  = pop_code && in_block && pos_sum[6];
  assign pop_coef = pop_code && in_block && !pos_sum[6];

  // Dequantize
  logic signed [8:0]  q_op;
  logic signed [25:0] scaled, rnd, vsel;
  logic signed [10:0] cval;
  logic [5:0]         waddr;
  always_comb begin
    q_op   = (scale == 6'd0) ? 9'sd2 : (qdv ? $signed({1'b0, qdata}) : 9'sd1);
    scaled = {{7{prod1[18]}}, prod1} * $signed({20'd0, scale});
    rnd    = (scaled + 26'sd4) >>> 3;
    vsel   = (dc || scale == 6'd0) ? {{7{prod1[18]}}, prod1} : rnd;
    if (vsel < -26'sd1024) begin
      cval = -11'sd1024;
    end else if (vsel > 26'sd1023) begin
      cval = 11'sd1023;
    end else begin
      cval = vsel[10:0];
    end
    waddr = (scale != 6'd0) ? ZIGZAG[pos[5:0]] : pos[5:0];
  end

  // IDCT sequencer and pipeline
  logic [9:0] cnt;
  logic       issuing;
  logic [5:0] src_addr, m_addr;
  logic       p1_v, p1_pass;
  logic [5:0] p1_o;
  logic [2:0] p1_z;
  logic signed [10:0] c_rd;
  logic       cv_rd;
  logic signed [13:0] b_rd;
  logic signed [15:0] m_rd;
  logic       p2_v, p2_pass;
  logic [5:0] p2_o;
  logic [2:0] p2_z;
  logic signed [26:0] prod;
  logic signed [31:0] acc, sum, res;
  logic signed [13:0] srcv;
  logic signed [12:0] mq;
  logic signed [15:0] sat;
  logic       p2_done;

  assign src_addr = {cnt[2:0], cnt[8:6]};
  assign m_addr   = {cnt[2:0], cnt[5:3]};

  always_comb begin
    srcv = p1_pass ? b_rd : (cv_rd ? {{3{c_rd[10]}}, c_rd} : 14'sd0);
    mq   = m_rd[15:3];
    sum  = ((p2_z == 3'd0) ? 32'sd0 : acc) + {{5{prod[26]}}, prod};
    res  = (sum + 32'sd4095) >>> 13;
    if (res < -32'sd32768) begin
      sat = -16'sd32768;
    end else if (res > 32'sd32767) begin
      sat = 16'sd32767;
    end else begin
      sat = res[15:0];
    end
    p2_done = p2_v && p2_pass && (p2_z == 3'd7) && (p2_o == 6'd63);
  end

  // Memories
  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == OP_QWRITE) begin
      qmem[q_item.idx] <= q_item.tval[7:0];
    end
    if (q_pop && q_item.op == OP_MWRITE) begin
      mmem[q_item.idx[5:0]] <= q_item.tval;
    end
    if (state == ST_MUL2) begin
      cmem[waddr] <= cval;
    end
    if (p2_v && !p2_pass && p2_z == 3'd7) begin
      bufm[p2_o] <= res[13:0];
    end
    qdata <= qmem[qaddr];
    c_rd  <= cmem[src_addr];
    b_rd  <= bufm[src_addr];
    m_rd  <= mmem[m_addr];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    qdv   <= qv[qaddr];
    cv_rd <= cv[src_addr];
    if (state == ST_MUL1) begin
      prod1 <= lvl * q_op;
    end
    if (pop_open || pop_coef) begin
      lvl <= q_item.word[9:0];
    end
    p1_pass <= cnt[9];
    p1_o    <= cnt[8:3];
    p1_z    <= cnt[2:0];
    p2_pass <= p1_pass;
    p2_o    <= p1_o;
    p2_z    <= p1_z;
    prod    <= srcv * mq;
    if (p2_v) begin
      acc <= sum;
    end
    sample       <= sat;
    sample_index <= p2_o;
    block_number <= bim;
    last         <= (p2_o == 6'd63);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_block <= 1'b0;
      scale    <= 6'd0;
      pos      <= 7'd0;
      bim      <= 3'd0;
      dc       <= 1'b0;
      qaddr    <= 7'd0;
      qv       <= '0;
      cv       <= '0;
      cnt      <= 10'd0;
      issuing  <= 1'b0;
      p1_v     <= 1'b0;
      p2_v     <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      p1_v   <= issuing;
      p2_v   <= p1_v;
      strobe <= p2_v && p2_pass && (p2_z == 3'd7);
      case (state)
        ST_IDLE: begin
          if (q_pop && q_item.op == OP_QWRITE) begin
            qv[q_item.idx] <= 1'b1;
          end
          if (pop_open) begin
            cv       <= '0;
            scale    <= q_item.word[15:10];
            pos      <= 7'd0;
            in_block <= 1'b1;
            dc       <= 1'b1;
            qaddr    <= {(bim < 3'd2), 6'd0};
            state    <= ST_QRD;
          end
          if (pop_coef) begin
            pos   <= pos_sum;
            dc    <= 1'b0;
            qaddr <= {(bim < 3'd2), pos_sum[5:0]};
            state <= ST_QRD;
          end
          if (pop_end) begin
            cnt     <= 10'd0;
            issuing <= 1'b1;
            state   <= ST_IDCT;
          end
        end
        ST_QRD: begin
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          cv[waddr] <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_IDCT: begin
          if (issuing) begin
            cnt <= cnt + 10'd1;
            if (cnt == 10'd1023) begin
              issuing <= 1'b0;
            end
          end
          if (p2_done) begin
            in_block <= 1'b0;
            pos      <= 7'd0;
            bim      <= (bim >= LAST_BLOCK) ? 3'd0 : bim + 3'd1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/mdec_block_dequant_idct_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdec_block_dequant_idct_top
// Run-length block decoder: dequantization, zigzag reorder, 2-pass IDCT.
// ----------------------------------------------------------------------------
//  channel  | handshake        | word contents
//  ---------+------------------+---------------------------------------------
//  input    | start / busy     | kind, code_word, table_index, table_value
//  result   | strobe (no stall)| sample, sample_index, block_number, last
//
//  Table writes complete as they are popped; a coefficient word passes a
//  quantizer read and two multiply states, the second storing the result. A
//  word that closes a block starts the IDCT: 2 x 512 multiply-accumulate
//  steps on one shared multiplier, one sample per eight-term sum in pass two.
//  The two-entry intake queue raises busy only when full; results cannot be
//  stalled. Reset clears the quantizer valid bits, so every entry reads as
//  one at once: no clearing pass.
// ----------------------------------------------------------------------------
module mdec_block_dequant_idct_top import mdbdi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [15:0]        code_word,
  input  logic [6:0]         table_index,
  input  logic signed [15:0] table_value,
  output logic               strobe,
  output logic signed [15:0] sample,
  output logic [5:0]         sample_index,
  output logic [2:0]         block_number,
  output logic               last
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Classify and hold incoming words
  mdbdi_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .code_word   (code_word),
    .table_index (table_index),
    .table_value (table_value),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  // Dequantize and transform
  mdbdi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .strobe       (strobe),
    .sample       (sample),
    .sample_index (sample_index),
    .block_number (block_number),
    .last         (last)
  );

  // Samples leave one per eight-term accumulation, never back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("samples emitted back to back");

  // The final sample of a block sits at the last raster position
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> (sample_index == 6'd63)) else $error("last misplaced");

  // The engine never drains an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");

endmodule

@@ tb/tb_mdec_block_dequant_idct_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mdec_block_dequant_idct_top
// Self-checking bench for the run-length block decoder. A queue of words
// (matrix load, directed blocks, then random well-formed blocks mixed with
// table writes, padding and ignored kinds) feeds a start/busy driver. A
// software decoder predicts every sample, and a monitor compares each
// strobed sample, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_mdec_block_dequant_idct_top;
  import mdbdi_pkg::*;

  localparam int IDLE_LIMIT = 3000;  // cycles with no word moved on either side
  localparam int DRAIN_WAIT = 1200;  // covers one full transform
  localparam int WORD_COUNT = 260;

  // kind with no meaning: the block drops it
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic [15:0]        code;
    logic [6:0]         idx;
    logic signed [15:0] tval;
  } word_t;

  typedef struct {
    logic signed [15:0] sample;
    logic [5:0]         index;
    logic [2:0]         blk;
    logic               last;
  } sample_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind = '0;
  logic [15:0]        code_word = '0;
  logic [6:0]         table_index = '0;
  logic signed [15:0] table_value = '0;
  logic               strobe;
  logic signed [15:0] sample;
  logic [5:0]         sample_index;
  logic [2:0]         block_number;
  logic               last;

  word_t   pending_words[$];
  sample_t expected_samples[$];

  // decoder state held by the bench
  logic [7:0]         quant_tab [128];
  logic signed [15:0] idct_coef [64];
  logic signed [10:0] coef_blk [64];
  int                 scan_pos;
  int                 blk_scale;
  bit                 block_open;
  int                 mb_block;

  logic word_taken = 1'b0;
  int   words_sent = 0;
  int   idle_cycles = 0;
  int   errors = 0;
  int   samples_checked = 0;
  int   blocks_closed = 0;

  always #2 clk = ~clk;

  mdec_block_dequant_idct_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .code_word(code_word), .table_index(table_index),
    .table_value(table_value), .strobe(strobe), .sample(sample),
    .sample_index(sample_index), .block_number(block_number), .last(last)
  );

  // append one word to the stimulus queue
  task automatic add_word(input word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  // store one dequantized coefficient, clamped to 11 bits
  task automatic store_coef(input longint value);
    longint c;
    int     k;
    c = value < -1024 ? -1024 : (value > 1023 ? 1023 : value);
    k = scan_pos & 63;
    if (blk_scale > 0) begin
      coef_blk[ZIGZAG[k]] = c[10:0];
    end else begin
      coef_blk[k] = c[10:0];
    end
  endtask

  // two-pass transform of the open block; queue its 64 samples
  task automatic transform_block();
    longint  src [64];
    longint  dst [64];
    longint  acc;
    longint  m;
    sample_t s;
    for (int i = 0; i < 64; i++) src[i] = longint'(coef_blk[i]);
    for (int p = 0; p < 2; p++) begin
      for (int x = 0; x < 8; x++) begin
        for (int y = 0; y < 8; y++) begin
          acc = 0;
          for (int z = 0; z < 8; z++) begin
            m = longint'(idct_coef[x + z * 8]);
            acc += src[y + z * 8] * (m >>> 3);
          end
          dst[x + y * 8] = (acc + 64'sh0FFF) >>> 13;
        end
      end
      src = dst;
    end
    for (int i = 0; i < 64; i++) begin
      acc = src[i] < -32768 ? -32768 : (src[i] > 32767 ? 32767 : src[i]);
      s.sample = acc[15:0];
      s.index  = i[5:0];
      s.blk    = mb_block[2:0];
      s.last   = (i == 63);
      expected_samples.insert(expected_samples.size(), s);
    end
  endtask

  // advance the decoder by one accepted word
  task automatic decode_word(input word_t w);
    int     qbase;
    longint lvl;
    qbase = mb_block < 2 ? 64 : 0;
    lvl   = longint'(signed'(w.code[9:0]));
    case (w.kind)
      KIND_QWRITE: begin
        quant_tab[w.idx] = w.tval[7:0];
      end
      KIND_MWRITE: begin
        if (w.idx < 64) idct_coef[w.idx] = w.tval;
      end
      KIND_CODE: begin
        if (!block_open) begin
          if (w.code != PAD_WORD) begin
            for (int i = 0; i < 64; i++) coef_blk[i] = '0;
            blk_scale  = int'(w.code[15:10]);
            scan_pos   = 0;
            block_open = 1'b1;
            store_coef(blk_scale == 0 ? lvl * 2 : lvl * longint'(quant_tab[qbase]));
          end
        end else begin
          scan_pos += int'(w.code[15:10]) + 1;
          if (scan_pos <= 63) begin
            if (blk_scale == 0) begin
              store_coef(lvl * 2);
            end else begin
              store_coef((lvl * longint'(quant_tab[qbase + scan_pos]) *
                          longint'(blk_scale) + 4) >>> 3);
            end
          end else begin
            transform_block();
            blocks_closed++;
            block_open = 1'b0;
            scan_pos   = 0;
            mb_block   = mb_block >= LAST_BLOCK ? 0 : mb_block + 1;
          end
        end
      end
      default: ;  // unused kind: drop it
    endcase
  endtask

  function automatic word_t mk(input logic [1:0] k, input logic [15:0] c,
                               input logic [6:0] ix, input logic [15:0] v);
    word_t w;
    w.kind = k; w.code = c; w.idx = ix; w.tval = v;
    return w;
  endfunction

  function automatic logic [15:0] code_of(input int run, input int lvl);
    logic [15:0] c;
    c[15:10] = run[5:0];
    c[9:0]   = lvl[9:0];
    return c;
  endfunction

  // one well-formed block with random content, sometimes roughed up
  task automatic queue_random_block();
    int pos;
    int run;
    int n;
    if ($urandom_range(9) == 0) begin
      add_word(mk(KIND_CODE, PAD_WORD, 7'($urandom), 16'($urandom)));
    end
    add_word(mk(KIND_CODE,
      code_of($urandom_range(9) == 0 ? 0 : int'($urandom_range(63, 1)), int'($urandom)),
      '0, '0));
    pos = 0;
    n = int'($urandom_range(6));
    for (int i = 0; i < n; i++) begin
      run = int'($urandom_range(7));
      pos += run + 1;
      add_word(mk(KIND_CODE, code_of(run, int'($urandom)), 7'($urandom), 16'($urandom)));
      case ($urandom_range(7))
        0: add_word(mk(KIND_QWRITE, 16'($urandom), 7'($urandom), 16'($urandom)));
        1: add_word(mk(KIND_UNUSED, 16'($urandom), 7'($urandom), 16'($urandom)));
        2: add_word(mk(KIND_MWRITE, 16'($urandom), 7'($urandom_range(127)),
                       16'($urandom)));
        default: ;
      endcase
    end
    // close: padding or a word whose run carries the position past the end
    if ($urandom_range(9) == 0) begin
      add_word(mk(KIND_CODE, PAD_WORD, '0, '0));
    end else begin
      add_word(mk(KIND_CODE,
        code_of(int'($urandom_range(63, 63 - pos)), int'($urandom)), '0, '0));
    end
  endtask

  // driver: present a new word once the previous one is taken
  always @(negedge clk) begin
    word_t w;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (pending_words.size() > 0 &&
          !((words_sent < 100 || words_sent > 180) && $urandom_range(99) < 6)) begin
        w = pending_words.pop_front();
        start       <= 1'b1;
        kind        <= w.kind;
        code_word   <= w.code;
        table_index <= w.idx;
        table_value <= w.tval;
        words_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, check every strobed sample
  always @(posedge clk) begin
    sample_t e;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= start && !busy;
      if (start && !busy) decode_word(mk(kind, code_word, table_index, table_value));
      if (strobe) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample %0d at index %0d", $time, sample, sample_index);
          errors++;
        end else begin
          e = expected_samples.pop_front();
          samples_checked++;
          if (sample !== e.sample) begin
            $display("%0t: sample exp %0d got %0d", $time, e.sample, sample);
            errors++;
          end
          if (sample_index !== e.index) begin
            $display("%0t: sample_index exp %0d got %0d", $time, e.index, sample_index);
            errors++;
          end
          if (block_number !== e.blk) begin
            $display("%0t: block_number exp %0d got %0d", $time, e.blk, block_number);
            errors++;
          end
          if (last !== e.last) begin
            $display("%0t: last exp %0d got %0d", $time, e.last, last);
            errors++;
          end
        end
      end
      // watchdog: nothing moving on either side for too long
      if ((start && !busy) || strobe) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("mdec_block_dequant_idct_top: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < 128; i++) quant_tab[i] = 8'd1;
    for (int i = 0; i < 64; i++) idct_coef[i] = '0;
    for (int i = 0; i < 64; i++) coef_blk[i] = '0;
    scan_pos = 0; blk_scale = 0; block_open = 1'b0; mb_block = 0;

    // load the whole matrix first so no block ever reads an unwritten entry
    for (int i = 0; i < 64; i++) begin
      add_word(mk(KIND_MWRITE, 16'($urandom), 7'(i), i == 0 ? 16'h7FFF :
                  (i == 9 ? 16'h8000 : 16'($urandom))));
    end

    // directed: padding skipped, extreme levels at scale zero, a closing run
    add_word(mk(KIND_CODE, PAD_WORD, '0, '0));
    add_word(mk(KIND_CODE, code_of(0, 511), '0, '0));
    add_word(mk(KIND_CODE, code_of(0, -512), '0, '0));
    add_word(mk(KIND_CODE, code_of(62, 1), '0, '0));
    add_word(mk(KIND_CODE, code_of(0, 0), '0, '0));   // opens the next block, scale zero
    // quantizer extremes in the upper half, ignored matrix index, unused kind
    add_word(mk(KIND_QWRITE, '0, 7'd64, 16'h00FF));
    add_word(mk(KIND_QWRITE, '0, 7'd127, 16'hFF00));
    add_word(mk(KIND_MWRITE, '0, 7'd100, 16'h1234));
    add_word(mk(KIND_UNUSED, 16'hFFFF, 7'd127, 16'hFFFF));
    // run 63 closes a block; quantizer write between blocks; padding closes
    add_word(mk(KIND_CODE, code_of(63, -512), '0, '0));
    add_word(mk(KIND_QWRITE, '0, 7'd66, 16'h00FF));
    add_word(mk(KIND_CODE, code_of(1, 511), '0, '0));
    add_word(mk(KIND_CODE, code_of(0, -512), '0, '0));
    add_word(mk(KIND_CODE, PAD_WORD, '0, '0));
    // longest run straight after the DC word
    add_word(mk(KIND_CODE, code_of(1, 3), '0, '0));
    add_word(mk(KIND_CODE, code_of(63, -1), '0, '0));

    while (pending_words.size() < WORD_COUNT) queue_random_block();

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_words.size() > 0 || start) @(posedge clk);
    while (expected_samples.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d words, %0d blocks closed, %0d samples checked.",
             words_sent, blocks_closed, samples_checked);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("mdec_block_dequant_idct_top: match");
    end else begin
      $display("mdec_block_dequant_idct_top: mismatch");
    end
    $finish;
  end

endmodule
